/* hw/rtl/vta_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vta_pkg
// Shared opcodes, operand kinds and front/back types for the variable table ALU.
// ----------------------------------------------------------------------------
package vta_pkg;

  localparam int DATA_W = 32;
  localparam int IDX_IN_W = 16;
  localparam int OP_W = 5;
  localparam int KIND_W = 2;

  // opcodes
  localparam logic [OP_W-1:0] OP_ADD   = 5'd0;
  localparam logic [OP_W-1:0] OP_SUB   = 5'd1;
  localparam logic [OP_W-1:0] OP_MUL   = 5'd2;
  localparam logic [OP_W-1:0] OP_DIV   = 5'd3;
  localparam logic [OP_W-1:0] OP_AND   = 5'd4;
  localparam logic [OP_W-1:0] OP_OR    = 5'd5;
  localparam logic [OP_W-1:0] OP_NOT   = 5'd6;
  localparam logic [OP_W-1:0] OP_GT    = 5'd7;
  localparam logic [OP_W-1:0] OP_EQ    = 5'd8;
  localparam logic [OP_W-1:0] OP_LT    = 5'd9;
  localparam logic [OP_W-1:0] OP_WGT   = 5'd10;
  localparam logic [OP_W-1:0] OP_WEQ   = 5'd11;
  localparam logic [OP_W-1:0] OP_WLT   = 5'd12;
  localparam logic [OP_W-1:0] OP_READ  = 5'd13;
  localparam logic [OP_W-1:0] OP_NE    = 5'd14;
  localparam logic [OP_W-1:0] OP_WNE   = 5'd15;
  localparam logic [OP_W-1:0] OP_MOD   = 5'd16;

  // operand kinds
  localparam logic [KIND_W-1:0] KIND_IMM = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REF = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LIT = 2'd2;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  // classified command as held in the queue
  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic                bad;
    logic                use_ref;
    logic [IDX_IN_W-1:0] tgt;
    logic [IDX_IN_W-1:0] ref_idx;
    logic [DATA_W-1:0]   n;
  } cmd_t;

  // back part status seen by the front and the checks
  typedef struct packed {
    logic clearing;
    logic wb;
  } bk_stat_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REF,
    ST_TGT,
    ST_EXEC,
    ST_MUL,
    ST_DIV,
    ST_DFIN
  } bk_state_t;

endpackage
`default_nettype wire

/* hw/rtl/vta_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vta_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module vta_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* hw/rtl/vta_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vta_front
// Accepts command beats, checks indexes, resolves the operand kind and
// holds classified commands in a two-entry queue for the back part.
// ----------------------------------------------------------------------------
module vta_front #(
  parameter int VAR_COUNT = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [4:0]               in_opcode,
  input  wire logic [15:0]              in_target_index,
  input  wire logic [1:0]               in_operand_kind,
  input  wire logic signed [31:0]       in_operand_value,
  input  wire logic [15:0]              in_operand_index,
  input  wire vta_pkg::bk_stat_t        bk_stat,
  output logic                          q_valid,
  output vta_pkg::cmd_t                 q_cmd,
  input  wire logic                     q_pop
);

  localparam logic [16:0] COUNT17 = 17'(VAR_COUNT);

  vta_pkg::cmd_t cmd_in;
  vta_pkg::cmd_t slot_r [2];
  logic          wr_ptr_r, rd_ptr_r;
  logic [1:0]    cnt_r;
  logic          push;
  logic          tgt_bad, ref_bad;

  // classify the incoming beat
  always_comb begin
    tgt_bad = {1'b0, in_target_index} >= COUNT17;
    ref_bad = (in_operand_kind == vta_pkg::KIND_REF) &&
              ({1'b0, in_operand_index} >= COUNT17);
    cmd_in.op      = in_opcode;
    cmd_in.bad     = tgt_bad || ref_bad;
    cmd_in.use_ref = in_operand_kind == vta_pkg::KIND_REF;
    cmd_in.tgt     = in_target_index;
    cmd_in.ref_idx = in_operand_index;
    if (in_operand_kind == vta_pkg::KIND_LIT) begin
      cmd_in.n = {24'd0, in_operand_value[7:0]};
    end else begin
      cmd_in.n = in_operand_value;
    end
  end

  assign in_ready = !bk_stat.clearing && (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = cnt_r != 2'd0;
  assign q_cmd    = slot_r[rd_ptr_r];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= cmd_in;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/vta_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vta_back
// Sequencer that clears the table, reads operands, runs the operation
// (registered multiply, bit-serial divide) and writes the target back.
// ----------------------------------------------------------------------------
module vta_back #(
  parameter int VAR_COUNT = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_valid,
  input  wire vta_pkg::cmd_t      q_cmd,
  output logic                    q_pop,
  output vta_pkg::bk_stat_t       bk_stat,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_status,
  output logic signed [31:0]      out_value
);

  localparam int IDX_W = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(VAR_COUNT - 1);

  vta_pkg::bk_state_t state_r, state_nxt;
  vta_pkg::cmd_t      cmd_r, cmd_nxt;
  logic [31:0]        t_r, t_nxt, n_r, n_nxt;
  logic [31:0]        quo_r, quo_nxt;
  logic [31:0]        rem_r, rem_nxt;
  logic [4:0]         dcnt_r, dcnt_nxt;
  logic [IDX_W-1:0]   clr_r, clr_nxt;
  logic               ov_r, ov_nxt, os_r, os_nxt;
  logic [31:0]        oval_r, oval_nxt;

  logic               we;
  logic [IDX_W-1:0]   waddr, raddr;
  logic [31:0]        wdata, rdata;
  logic               res_ld, res_st;
  logic [31:0]        res_val;

  // simple operation results
  logic        t_nz, n_nz, eq, lt, gt;
  logic [31:0] simple_t;
  logic        simple_st;
  logic [32:0] rem_sh, rem_sub;
  logic [31:0] a_mag, b_mag, q_fin, r_fin;

  vta_ram #(.WIDTH(32), .DEPTH(VAR_COUNT)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // compare and logic helpers
  always_comb begin
    t_nz = t_r != 32'd0;
    n_nz = n_r != 32'd0;
    eq   = t_r == n_r;
    lt   = $signed(t_r) < $signed(n_r);
    gt   = $signed(n_r) < $signed(t_r);
    simple_t  = t_r;
    simple_st = vta_pkg::STATUS_OK;
    case (cmd_r.op)
      vta_pkg::OP_ADD: simple_t = t_r + n_r;
      vta_pkg::OP_SUB: simple_t = t_r - n_r;
      vta_pkg::OP_AND: simple_t = {31'd0, t_nz && n_nz};
      vta_pkg::OP_OR:  simple_t = {31'd0, t_nz || n_nz};
      vta_pkg::OP_NOT: simple_t = {31'd0, !t_nz};
      vta_pkg::OP_GT:  simple_t = {31'd0, gt};
      vta_pkg::OP_EQ:  simple_t = {31'd0, eq};
      vta_pkg::OP_LT:  simple_t = {31'd0, lt};
      vta_pkg::OP_NE:  simple_t = {31'd0, !eq};
      vta_pkg::OP_WGT: simple_st = !gt;
      vta_pkg::OP_WEQ: simple_st = !eq;
      vta_pkg::OP_WLT: simple_st = !lt;
      vta_pkg::OP_WNE: simple_st = eq;
      default: simple_t = t_r;
    endcase
  end

  // divider step and sign fix-up
  always_comb begin
    a_mag   = t_r[31] ? (32'd0 - t_r) : t_r;
    b_mag   = n_r[31] ? (32'd0 - n_r) : n_r;
    rem_sh  = {rem_r, quo_r[31]};
    rem_sub = rem_sh - {1'b0, b_mag};
    q_fin   = (t_r[31] ^ n_r[31]) ? (32'd0 - quo_r) : quo_r;
    r_fin   = t_r[31] ? (32'd0 - rem_r) : rem_r;
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vta_pkg::ST_CLEAR;
      clr_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    t_r    <= t_nxt;
    n_r    <= n_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    dcnt_r <= dcnt_nxt;
    os_r   <= os_nxt;
    oval_r <= oval_nxt;
  end

  // next state and outputs
  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    t_nxt     = t_r;
    n_nxt     = n_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    dcnt_nxt  = dcnt_r;
    clr_nxt   = clr_r;
    ov_nxt    = ov_r && !out_ready;
    os_nxt    = os_r;
    oval_nxt  = oval_r;
    q_pop     = 1'b0;
    we        = 1'b0;
    waddr     = cmd_r.tgt[IDX_W-1:0];
    wdata     = t_r;
    raddr     = cmd_r.tgt[IDX_W-1:0];
    res_ld    = 1'b0;
    res_st    = vta_pkg::STATUS_OK;
    res_val   = t_r;
    case (state_r)
      vta_pkg::ST_CLEAR: begin
        we      = 1'b1;
        waddr   = clr_r;
        wdata   = 32'd0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == LAST_IDX) begin
          state_nxt = vta_pkg::ST_IDLE;
        end
      end
      vta_pkg::ST_IDLE: begin
        raddr = q_cmd.use_ref ? q_cmd.ref_idx[IDX_W-1:0] : q_cmd.tgt[IDX_W-1:0];
        if (q_valid && !ov_r) begin
          q_pop   = 1'b1;
          cmd_nxt = q_cmd;
          n_nxt   = q_cmd.n;
          if (q_cmd.bad) begin
            ov_nxt   = 1'b1;
            os_nxt   = vta_pkg::STATUS_FAIL;
            oval_nxt = 32'd0;
          end else if (q_cmd.use_ref) begin
            state_nxt = vta_pkg::ST_REF;
          end else begin
            state_nxt = vta_pkg::ST_TGT;
          end
        end
      end
      vta_pkg::ST_REF: begin
        n_nxt     = rdata;
        state_nxt = vta_pkg::ST_TGT;
      end
      vta_pkg::ST_TGT: begin
        t_nxt     = rdata;
        state_nxt = vta_pkg::ST_EXEC;
      end
      vta_pkg::ST_EXEC: begin
        if (cmd_r.op == vta_pkg::OP_MUL) begin
          t_nxt     = t_r * n_r;
          state_nxt = vta_pkg::ST_MUL;
        end else if ((cmd_r.op == vta_pkg::OP_DIV || cmd_r.op == vta_pkg::OP_MOD)
                     && n_r != 32'd0) begin
          quo_nxt   = a_mag;
          rem_nxt   = '0;
          dcnt_nxt  = '0;
          state_nxt = vta_pkg::ST_DIV;
        end else begin
          res_ld  = 1'b1;
          res_st  = simple_st;
          res_val = simple_t;
        end
      end
      vta_pkg::ST_MUL: begin
        res_ld = 1'b1;
      end
      vta_pkg::ST_DIV: begin
        // one quotient bit per cycle
        if (!rem_sub[32]) begin
          rem_nxt = rem_sub[31:0];
          quo_nxt = {quo_r[30:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[31:0];
          quo_nxt = {quo_r[30:0], 1'b0};
        end
        dcnt_nxt = dcnt_r + 1'b1;
        if (dcnt_r == 5'd31) begin
          state_nxt = vta_pkg::ST_DFIN;
        end
      end
      vta_pkg::ST_DFIN: begin
        res_ld  = 1'b1;
        res_val = (cmd_r.op == vta_pkg::OP_DIV) ? q_fin : r_fin;
      end
      default: state_nxt = vta_pkg::ST_IDLE;
    endcase
    // write back and load the result beat
    if (res_ld) begin
      we        = 1'b1;
      wdata     = res_val;
      ov_nxt    = 1'b1;
      os_nxt    = res_st;
      oval_nxt  = res_val;
      state_nxt = vta_pkg::ST_IDLE;
    end
  end

  assign bk_stat.clearing = state_r == vta_pkg::ST_CLEAR;
  assign bk_stat.wb       = res_ld;
  assign out_valid        = ov_r;
  assign out_status       = os_r;
  assign out_value        = oval_r;

endmodule
`default_nettype wire

/* hw/rtl/variable_table_alu_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// variable_table_alu_top
// Table of signed 32-bit variables updated by one command per beat.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  in_      input      in_valid/in_ready    opcode, target_index, operand_kind,
//                                           operand_value, operand_index
//  out_     output     out_valid/out_ready  status, value
//
// A command reads its reference operand (ST_REF), if any, then its target
// (ST_TGT) through the single-port table read before ST_EXEC; multiply adds
// ST_MUL for its register; divide and modulo run the one-bit-per-cycle divider.
// After reset a clearing pass zeroes every table entry; in_ready
// stays low meanwhile. A two-entry queue takes beats while the back works;
// a waiting result holds the back but not the queue.
module variable_table_alu_top #(
  parameter int VAR_COUNT = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [4:0]         in_opcode,
  input  wire logic [15:0]        in_target_index,
  input  wire logic [1:0]         in_operand_kind,
  input  wire logic signed [31:0] in_operand_value,
  input  wire logic [15:0]        in_operand_index,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_status,
  output logic signed [31:0]      out_value
);

  logic              q_valid, q_pop;
  vta_pkg::cmd_t     q_cmd;
  vta_pkg::bk_stat_t bk_stat;

  // accept and classify
  vta_front #(.VAR_COUNT(VAR_COUNT)) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_target_index  (in_target_index),
    .in_operand_kind  (in_operand_kind),
    .in_operand_value (in_operand_value),
    .in_operand_index (in_operand_index),
    .bk_stat          (bk_stat),
    .q_valid          (q_valid),
    .q_cmd            (q_cmd),
    .q_pop            (q_pop)
  );

  // execute and write back
  vta_back #(.VAR_COUNT(VAR_COUNT)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .q_pop      (q_pop),
    .bk_stat    (bk_stat),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_status (out_status),
    .out_value  (out_value)
  );

  // no beat taken while the table is being cleared
  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.clearing |-> !in_ready) else $error("beat accepted during clear");

  // a write back always presents a result beat next cycle
  a_wb_result: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.wb |=> out_valid) else $error("write back without result");

  // a command leaves the queue only when the result slot is free
  a_pop_free: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (q_valid && !out_valid)) else $error("pop with result slot busy");

  // no write back during clear
  a_wb_not_clear: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.clearing |-> !bk_stat.wb) else $error("write back during clear");

endmodule
`default_nettype wire
